>>> hdl/kscb_pkg.sv
// ----------------------------------------------------------------------------
// kscb_pkg
// Shared types, codes and byte arithmetic for the keyed substitution cipher.
// ----------------------------------------------------------------------------
package kscb_pkg;

  localparam int unsigned KEY_DEPTH_DEF = 64;
  localparam int unsigned TABLE_SIZE    = 255;
  localparam int unsigned OUT_DEPTH     = 4;
  localparam int unsigned OUT_PTR_W     = $clog2(OUT_DEPTH);
  localparam int unsigned OUT_CNT_W     = $clog2(OUT_DEPTH + 1);
  localparam int unsigned CFG_DATA_W    = 7;

  typedef enum logic [1:0] {
    CMD_LOAD_TABLE = 2'd0,
    CMD_LOAD_KEY   = 2'd1,
    CMD_START      = 2'd2,
    CMD_DATA       = 2'd3
  } cmd_e;

  typedef enum logic {
    REG_MODE       = 1'b0,
    REG_KEY_LENGTH = 1'b1
  } reg_e;

  typedef struct packed {
    logic       en;
    logic [7:0] idx;
    logic [7:0] val;
  } inv_req_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       not_found;
  } res_t;

  function automatic logic [7:0] add_mod255(input logic [7:0] a, input logic [7:0] b);
    logic [8:0] sum;
    logic [8:0] red;
    sum = {1'b0, a} + {1'b0, b};
    red = (sum >= 9'd255) ? (sum - 9'd255) : sum;
    return (red == 9'd255) ? 8'd0 : red[7:0];
  endfunction

  function automatic logic [7:0] sub_mod255(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] aa;
    logic [7:0] bb;
    logic [8:0] diff;
    aa   = (a == 8'hFF) ? 8'd0 : a;
    bb   = (b == 8'hFF) ? 8'd0 : b;
    diff = {1'b0, aa} + 9'd255 - {1'b0, bb};
    diff = (diff >= 9'd255) ? (diff - 9'd255) : diff;
    return diff[7:0];
  endfunction

endpackage

>>> hdl/kscb_key_unit.sv
// ----------------------------------------------------------------------------
// kscb_key_unit
// Key byte memory and key position; reads the key for each request.
// ----------------------------------------------------------------------------
module kscb_key_unit #(
  parameter int unsigned KEY_DEPTH = kscb_pkg::KEY_DEPTH_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 acc_i,
  input  kscb_pkg::cmd_e       cmd_i,
  input  logic [7:0]           idx_i,
  input  logic [7:0]           val_i,
  input  logic [6:0]           key_length_i,
  output logic [7:0]           key_o
);
  import kscb_pkg::*;

  localparam int unsigned PW = (KEY_DEPTH > 1) ? $clog2(KEY_DEPTH) : 1;

  logic [7:0]    mem [KEY_DEPTH];
  logic [7:0]    rd_q;
  logic [PW-1:0] pos_q, pos_d;
  logic [8:0]    eff_len;
  logic [8:0]    pos_inc;
  logic          wr_en;

  assign wr_en = acc_i && (cmd_i == CMD_LOAD_KEY) && ({1'b0, idx_i} < 9'(KEY_DEPTH));

  always_comb begin
    if (key_length_i == 7'd0) begin
      eff_len = 9'd1;
    end else if ({2'b0, key_length_i} > 9'(KEY_DEPTH)) begin
      eff_len = 9'(KEY_DEPTH);
    end else begin
      eff_len = {2'b0, key_length_i};
    end
  end

  assign pos_inc = 9'(pos_q) + 9'd1;

  always_comb begin
    pos_d = pos_q;
    if (acc_i && (cmd_i == CMD_START)) begin
      pos_d = '0;
    end else if (acc_i && (cmd_i == CMD_DATA)) begin
      pos_d = (pos_inc >= eff_len) ? '0 : pos_inc[PW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
    end else begin
      pos_q <= pos_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[idx_i[PW-1:0]] <= val_i;
    end
    rd_q <= mem[pos_q];
  end

  assign key_o = rd_q;

endmodule

>>> hdl/kscb_inv_unit.sv
// ----------------------------------------------------------------------------
// kscb_inv_unit
// Inverse table memory with valid bits; keeps the lowest index per byte.
// ----------------------------------------------------------------------------
module kscb_inv_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [7:0]         rd_addr_i,
  input  logic [7:0]         look_val_i,
  input  kscb_pkg::inv_req_t req_i,
  output logic               hit_o,
  output logic [7:0]         idx_o
);
  import kscb_pkg::*;

  logic [7:0]   mem [256];
  logic [7:0]   rd_q;
  logic [255:0] valid_q;
  logic         byp_en_q;
  logic [7:0]   byp_addr_q;
  logic [7:0]   byp_data_q;
  logic [7:0]   cur;
  logic         we;

  assign hit_o = valid_q[look_val_i];
  assign cur   = (byp_en_q && (byp_addr_q == look_val_i)) ? byp_data_q : rd_q;
  assign idx_o = cur;
  assign we    = req_i.en && (!hit_o || (req_i.idx < cur));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      byp_en_q <= 1'b0;
    end else begin
      byp_en_q <= we;
      if (we) begin
        valid_q[req_i.val] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    byp_addr_q <= req_i.val;
    byp_data_q <= req_i.idx;
    if (we) begin
      mem[req_i.val] <= req_i.idx;
    end
    rd_q <= mem[rd_addr_i];
  end

endmodule

>>> hdl/kscb_sub_unit.sv
// ----------------------------------------------------------------------------
// kscb_sub_unit
// Substitution table memory: written on load, read for encryption.
// ----------------------------------------------------------------------------
module kscb_sub_unit (
  input  logic       clk_i,
  input  logic       wr_en_i,
  input  logic [7:0] wr_addr_i,
  input  logic [7:0] wr_data_i,
  input  logic [7:0] rd_addr_i,
  output logic [7:0] rd_data_o
);
  import kscb_pkg::*;

  logic [7:0] mem [TABLE_SIZE];
  logic [7:0] rd_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    rd_q <= mem[rd_addr_i];
  end

  assign rd_data_o = rd_q;

endmodule

>>> hdl/kscb_out_fifo.sv
// ----------------------------------------------------------------------------
// kscb_out_fifo
// Small result queue that decouples the pipeline from the output side.
// ----------------------------------------------------------------------------
module kscb_out_fifo (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         push_i,
  input  kscb_pkg::res_t               push_data_i,
  output logic                         valid_o,
  input  logic                         ready_i,
  output kscb_pkg::res_t               data_o,
  output logic [kscb_pkg::OUT_CNT_W-1:0] count_o
);
  import kscb_pkg::*;

  res_t                 arr_q [OUT_DEPTH];
  logic [OUT_PTR_W-1:0] wr_ptr_q;
  logic [OUT_PTR_W-1:0] rd_ptr_q;
  logic [OUT_CNT_W-1:0] cnt_q;
  logic                 pop;

  assign valid_o = (cnt_q != '0);
  assign pop     = valid_o && ready_i;
  assign data_o  = arr_q[rd_ptr_q];
  assign count_o = cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + OUT_PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + OUT_PTR_W'(1);
      end
      if (push_i && !pop) begin
        cnt_q <= cnt_q + OUT_CNT_W'(1);
      end else if (pop && !push_i) begin
        cnt_q <= cnt_q - OUT_CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      arr_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

>>> hdl/keyed_substitution_byte_cipher.sv
// ----------------------------------------------------------------------------
// keyed_substitution_byte_cipher
// Data path: a data request passes the key and inverse read, then the
// substitution read, then waits in the result queue.
// Throughput: one request per cycle while the result queue has room (in_ready_o).
// Reset: clears key position, mode and inverse valid bits, sets key length to 1;
// no clearing pass, requests are taken right after reset.
// ----------------------------------------------------------------------------
module keyed_substitution_byte_cipher #(
  parameter int unsigned KEY_DEPTH = kscb_pkg::KEY_DEPTH_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [1:0]                      command_i,
  input  logic [7:0]                      index_i,
  input  logic [7:0]                      value_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [7:0]                      out_byte_o,
  output logic                            not_found_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic                            cfg_index_i,
  input  logic [kscb_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import kscb_pkg::*;

  logic                 in_acc;
  cmd_e                 in_cmd;
  logic                 mode_q;
  logic [6:0]           key_length_q;
  logic                 s1_valid_q;
  cmd_e                 s1_cmd_q;
  logic [7:0]           s1_idx_q;
  logic [7:0]           s1_val_q;
  logic                 s1_data;
  logic                 s2_valid_q;
  logic                 s2_mode_q;
  logic [7:0]           s2_dec_q;
  logic                 s2_nf_q;
  logic [7:0]           key;
  logic                 inv_hit;
  logic [7:0]           inv_idx;
  logic [7:0]           sub_rd;
  inv_req_t             inv_req;
  res_t                 push_res;
  res_t                 head;
  logic [OUT_CNT_W-1:0] fifo_cnt;
  logic [OUT_CNT_W:0]   occ;

  assign in_cmd  = cmd_e'(command_i);
  assign in_acc  = in_valid_i && in_ready_o;
  assign s1_data = s1_valid_q && (s1_cmd_q == CMD_DATA);

  assign occ = (OUT_CNT_W + 1)'(fifo_cnt) + (OUT_CNT_W + 1)'(s1_data)
             + (OUT_CNT_W + 1)'(s2_valid_q);
  assign in_ready_o  = (occ < (OUT_CNT_W + 1)'(OUT_DEPTH));
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q       <= 1'b0;
      key_length_q <= 7'd1;
    end else if (cfg_valid_i) begin
      unique case (reg_e'(cfg_index_i))
        REG_MODE:       mode_q       <= cfg_data_i[0];
        REG_KEY_LENGTH: key_length_q <= cfg_data_i[6:0];
        default:        mode_q       <= mode_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= in_acc;
      s2_valid_q <= s1_data;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_cmd_q  <= in_cmd;
    s1_idx_q  <= index_i;
    s1_val_q  <= value_i;
    s2_mode_q <= mode_q;
    s2_dec_q  <= sub_mod255(inv_hit ? inv_idx : 8'hFF, key);
    s2_nf_q   <= !inv_hit;
  end

  kscb_key_unit #(
    .KEY_DEPTH(KEY_DEPTH)
  ) u_key (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .acc_i       (in_acc),
    .cmd_i       (in_cmd),
    .idx_i       (index_i),
    .val_i       (value_i),
    .key_length_i(key_length_q),
    .key_o       (key)
  );

  assign inv_req.en  = s1_valid_q && (s1_cmd_q == CMD_LOAD_TABLE)
                    && (s1_idx_q < 8'(TABLE_SIZE));
  assign inv_req.idx = s1_idx_q;
  assign inv_req.val = s1_val_q;

  kscb_inv_unit u_inv (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_addr_i (value_i),
    .look_val_i(s1_val_q),
    .req_i     (inv_req),
    .hit_o     (inv_hit),
    .idx_o     (inv_idx)
  );

  kscb_sub_unit u_sub (
    .clk_i    (clk_i),
    .wr_en_i  (in_acc && (in_cmd == CMD_LOAD_TABLE) && (index_i < 8'(TABLE_SIZE))),
    .wr_addr_i(index_i),
    .wr_data_i(value_i),
    .rd_addr_i(add_mod255(s1_val_q, key)),
    .rd_data_o(sub_rd)
  );

  assign push_res.out_byte  = s2_mode_q ? s2_dec_q : sub_rd;
  assign push_res.not_found = s2_mode_q && s2_nf_q;

  kscb_out_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (s2_valid_q),
    .push_data_i(push_res),
    .valid_o    (out_valid_o),
    .ready_i    (out_ready_i),
    .data_o     (head),
    .count_o    (fifo_cnt)
  );

  assign out_byte_o  = head.out_byte;
  assign not_found_o = head.not_found;

endmodule

>>> verif/kscb_tb_pkg.sv
// ----------------------------------------------------------------------------
// kscb_tb_pkg
// Scoreboard for the keyed substitution cipher: mirrors the table, inverse
// map, key bytes, key position and registers, and queues the byte that each
// accepted data request should produce.
// ----------------------------------------------------------------------------
package kscb_tb_pkg;

  import kscb_pkg::*;

  class cipher_scoreboard;

    bit [7:0]    sub_tbl [TABLE_SIZE];
    bit [7:0]    inv_idx [256];
    bit          inv_ok [256];
    bit [7:0]    key_bytes [KEY_DEPTH_DEF];
    int unsigned key_pos;
    bit          dec_mode;
    bit [6:0]    key_len;
    res_t        cipher_q[$];
    int unsigned errors;

    function new();
      key_pos  = 0;
      dec_mode = 1'b0;
      key_len  = 7'd1;
      errors   = 0;
    endfunction

    function void set_reg(reg_e r, bit [6:0] d);
      if (r == REG_MODE) begin
        dec_mode = d[0];
      end else begin
        key_len = d;
      end
    endfunction

    function int unsigned pending();
      return cipher_q.size();
    endfunction

    function void note_request(cmd_e cmd, bit [7:0] idx, bit [7:0] val);
      res_t        r;
      int unsigned k;
      int unsigned pos;
      int unsigned len;
      case (cmd)
        CMD_LOAD_TABLE: begin
          if (idx < TABLE_SIZE) begin
            sub_tbl[idx] = val;
            if (!inv_ok[val] || idx < inv_idx[val]) begin
              inv_idx[val] = idx;
              inv_ok[val]  = 1'b1;
            end
          end
        end
        CMD_LOAD_KEY: begin
          if (idx < KEY_DEPTH_DEF) key_bytes[idx] = val;
        end
        CMD_START: begin
          key_pos = 0;
        end
        default: begin
          k = key_bytes[key_pos];
          if (!dec_mode) begin
            r.out_byte  = sub_tbl[(int'(val) + k) % 255];
            r.not_found = 1'b0;
          end else begin
            pos         = inv_ok[val] ? inv_idx[val] : 255;
            r.out_byte  = 8'(((pos % 255) + 255 - (k % 255)) % 255);
            r.not_found = !inv_ok[val];
          end
          cipher_q.push_back(r);
          len = (key_len == 0) ? 1 : (key_len > KEY_DEPTH_DEF) ? KEY_DEPTH_DEF : key_len;
          key_pos = (key_pos + 1 >= len) ? 0 : key_pos + 1;
        end
      endcase
    endfunction

    function void check_result(logic [7:0] got_byte, logic got_nf);
      res_t want;
      if (cipher_q.size() == 0) begin
        errors++;
        if (errors <= 10) begin
          $display("unexpected result: out_byte=%02h not_found=%0b", got_byte, got_nf);
        end
        return;
      end
      want = cipher_q.pop_front();
      if (want.out_byte !== got_byte || want.not_found !== got_nf) begin
        errors++;
        if (errors <= 10) begin
          $display("mismatch: expected out_byte=%02h not_found=%0b, got out_byte=%02h not_found=%0b",
                   want.out_byte, want.not_found, got_byte, got_nf);
        end
      end
    endfunction

  endclass

endpackage

>>> verif/keyed_substitution_byte_cipher_tb.sv
// ----------------------------------------------------------------------------
// keyed_substitution_byte_cipher_tb
// Loads tables and keys, runs directed and random messages in both modes
// under several key lengths and handshake stall patterns, and compares every
// output byte and not-found flag against a scoreboard prediction.
// ----------------------------------------------------------------------------
module keyed_substitution_byte_cipher_tb;

  timeunit 1ns;
  timeprecision 1ps;

  import kscb_pkg::*;
  import kscb_tb_pkg::*;

  localparam int unsigned LIMIT = 100000;

  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       in_valid_i  = 1'b0;
  logic       in_ready_o;
  logic [1:0] command_i   = 2'd0;
  logic [7:0] index_i     = 8'd0;
  logic [7:0] value_i     = 8'd0;
  logic       out_valid_o;
  logic       out_ready_i = 1'b0;
  logic [7:0] out_byte_o;
  logic       not_found_o;
  logic       cfg_valid_i = 1'b0;
  logic       cfg_ready_o;
  logic       cfg_index_i = 1'b0;
  logic [6:0] cfg_data_i  = 7'd0;

  cipher_scoreboard sb = new();

  int unsigned send_idle_pct = 10;
  int unsigned recv_idle_pct = 75;
  int unsigned sent_cnt      = 0;
  int unsigned cycle_cnt     = 0;
  bit          hold_go       = 1'b0;
  logic        rx_hold       = 1'b0;
  bit          tbl_done [TABLE_SIZE];
  bit          key_done [KEY_DEPTH_DEF];
  int unsigned tbl_written[$];

  keyed_substitution_byte_cipher i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .command_i   (command_i),
    .index_i     (index_i),
    .value_i     (value_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_byte_o  (out_byte_o),
    .not_found_o (not_found_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  always @(negedge clk_i) begin
    out_ready_i <= !rx_hold && ($urandom_range(99) >= recv_idle_pct);
  end

  initial begin
    wait (hold_go);
    @(negedge clk_i);
    rx_hold <= 1'b1;
    repeat (300) @(negedge clk_i);
    rx_hold <= 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      sb.check_result(out_byte_o, not_found_o);
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == LIMIT) begin
      $display("keyed_substitution_byte_cipher_tb: done, errors");
      $finish;
    end
  end

  task automatic send_request(input cmd_e cmd, input bit [7:0] idx, input bit [7:0] val);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(negedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid_i <= 1'b1;
    command_i  <= cmd;
    index_i    <= idx;
    value_i    <= val;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_request(cmd, idx, val);
    sent_cnt++;
    @(negedge clk_i);
  endtask

  task automatic send_table(input bit [7:0] idx, input bit [7:0] val);
    if (idx < TABLE_SIZE && !tbl_done[idx]) begin
      tbl_done[idx] = 1'b1;
      tbl_written.push_back(idx);
    end
    send_request(CMD_LOAD_TABLE, idx, val);
  endtask

  task automatic send_key(input bit [7:0] idx, input bit [7:0] val);
    if (idx < KEY_DEPTH_DEF) key_done[idx] = 1'b1;
    send_request(CMD_LOAD_KEY, idx, val);
  endtask

  // pick: encrypt mode picks a byte that reads only defined table entries
  task automatic send_data(input bit pick, input bit [7:0] v_in);
    int unsigned k;
    int unsigned t;
    bit [7:0]    v;
    if (!key_done[sb.key_pos]) send_key(8'(sb.key_pos), 8'($urandom));
    k = sb.key_bytes[sb.key_pos];
    v = v_in;
    if (pick) begin
      if (!sb.dec_mode) begin
        if (tbl_written.size() == 0) send_table(8'($urandom_range(254)), 8'($urandom));
        t = tbl_written[$urandom_range(tbl_written.size() - 1)];
        v = 8'((t + 255 - (k % 255)) % 255);
        if (v == 8'd0 && $urandom_range(1) == 1) v = 8'd255;
      end else if (tbl_written.size() != 0 && $urandom_range(99) < 70) begin
        v = sb.sub_tbl[tbl_written[$urandom_range(tbl_written.size() - 1)]];
      end else begin
        v = 8'($urandom);
      end
    end
    send_request(CMD_DATA, 8'($urandom_range(254)), v);
  endtask

  task automatic write_reg(input reg_e r, input bit [6:0] d);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= r;
    cfg_data_i  <= d;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.set_reg(r, d);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    @(negedge clk_i);
  endtask

  // hold until every expected byte is out, then let loads retire
  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  task automatic send_message();
    if ($urandom_range(99) < 30) begin
      repeat ($urandom_range(1, 6)) send_table(8'($urandom_range(255)), 8'($urandom));
    end
    if ($urandom_range(99) < 20) begin
      repeat ($urandom_range(1, 4)) send_key(8'($urandom_range(80)), 8'($urandom));
    end
    if ($urandom_range(99) < 85) begin
      send_request(CMD_START, 8'($urandom_range(254)), 8'($urandom));
    end
    repeat ($urandom_range(1, 16)) send_data(1'b1, 8'h00);
  endtask

  task automatic run_phase(input bit mode_dec, input bit [6:0] klen,
                           input int unsigned tx_idle, input int unsigned rx_idle);
    int unsigned target;
    drain();
    write_reg(REG_MODE, {6'($urandom), mode_dec});
    write_reg(REG_KEY_LENGTH, klen);
    send_idle_pct = tx_idle;
    recv_idle_pct = rx_idle;
    target = sent_cnt + 100;
    while (sent_cnt < target) send_message();
  endtask

  initial begin
    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    write_reg(REG_MODE, 7'd0);
    write_reg(REG_KEY_LENGTH, 7'd2);
    send_table(8'd0, 8'hFF);
    send_table(8'd254, 8'h00);
    send_table(8'd255, 8'h5A);
    send_table(8'd100, 8'h33);
    send_table(8'd100, 8'h44);
    send_table(8'd50, 8'h44);
    send_table(8'd200, 8'h44);
    send_key(8'd0, 8'h00);
    send_key(8'd1, 8'hFF);
    send_key(8'd63, 8'h80);
    send_key(8'd64, 8'h11);
    send_request(CMD_START, 8'd0, 8'd0);
    send_data(1'b0, 8'h00);
    send_data(1'b0, 8'hFF);
    send_request(CMD_START, 8'd254, 8'hFF);
    send_data(1'b0, 8'hFF);
    send_data(1'b0, 8'hFE);
    send_data(1'b0, 8'd100);

    drain();
    write_reg(REG_MODE, 7'd1);
    send_request(CMD_START, 8'd7, 8'd7);
    send_data(1'b0, 8'h44);
    send_data(1'b0, 8'h33);
    send_data(1'b0, 8'h99);
    send_data(1'b0, 8'hFF);

    // lower the key length with the position beyond it
    drain();
    write_reg(REG_KEY_LENGTH, 7'd64);
    send_request(CMD_START, 8'd1, 8'd1);
    repeat (3) send_data(1'b1, 8'h00);
    drain();
    write_reg(REG_KEY_LENGTH, 7'd2);
    repeat (2) send_data(1'b1, 8'h00);

    drain();
    write_reg(REG_MODE, 7'd0);
    repeat (24) send_table(8'($urandom_range(255)), 8'($urandom));

    run_phase(1'b0, 7'd1, 10, 75);
    run_phase(1'b1, 7'd64, 10, 75);
    run_phase(1'b0, 7'd0, 75, 10);
    run_phase(1'b1, 7'd127, 75, 10);
    drain();
    hold_go = 1'b1;
    run_phase(1'($urandom), 7'($urandom_range(1, 64)), 0, 0);
    run_phase(1'($urandom), 7'($urandom_range(0, 127)), 0, 0);
    drain();

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("keyed_substitution_byte_cipher_tb: done, clean");
    end else begin
      $display("keyed_substitution_byte_cipher_tb: done, errors");
    end
    $finish;
  end

endmodule
